[rtl/sgh_pkg.sv]
// sgh_pkg: shared types and constants for the symbol repeat-gap histogram
// operation codes, histogram port control group and default parameter values
// no dependencies
`default_nettype none

package sgh_pkg;

    // fixed field widths at the block boundary
    localparam int OP_W        = 2;
    localparam int SYMBOL_W    = 4;
    localparam int INDEX_W     = 8;
    localparam int GAP_OUT_W   = 8;
    localparam int COUNT_OUT_W = 32;

    // default parameter values
    localparam int DEF_SYMBOL_BITS = 4;
    localparam int DEF_MAX_GAP     = 128;
    localparam int DEF_COUNT_WIDTH = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // control group toward the histogram store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_hist_ctl;

endpackage

`default_nettype wire

[rtl/sgh_age_track.sv]
// sgh_age_track: per-symbol saturating age registers
// gives the age of the addressed symbol; does not use sgh_pkg
`default_nettype none

module sgh_age_track #(
    parameter int SYMBOL_BITS = 4,
    parameter int MAX_GAP     = 128,
    localparam int NUM_SYM    = 1 << SYMBOL_BITS,
    localparam int AGE_W      = $clog2(MAX_GAP + 2)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [SYMBOL_BITS-1:0] i_sym,
    input  wire logic                   i_upd,
    input  wire logic                   i_clr,
    output logic      [AGE_W-1:0]       o_age,
    output logic                        o_seen
);

    localparam logic [AGE_W-1:0] UNSEEN = AGE_W'(MAX_GAP + 1);

    logic [AGE_W-1:0] r_age [NUM_SYM];
    logic [AGE_W-1:0] n_age [NUM_SYM];

    assign o_age  = r_age[i_sym];
    assign o_seen = (r_age[i_sym] != UNSEEN);

    always_comb begin
        for (int k = 0; k < NUM_SYM; k++) begin
            n_age[k] = r_age[k];
            if (i_clr) begin
                n_age[k] = UNSEEN;
            end else if (i_upd) begin
                if (i_sym == SYMBOL_BITS'(k)) begin
                    n_age[k] = '0;
                end else if (r_age[k] != UNSEEN) begin
                    n_age[k] = r_age[k] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SYM; k++) begin
                r_age[k] <= UNSEEN;
            end
        end else begin
            for (int k = 0; k < NUM_SYM; k++) begin
                r_age[k] <= n_age[k];
            end
        end
    end

    // pushed symbol restarts at zero
    a_push_zeroes_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd |=> (r_age[$past(i_sym)] == '0))
        else $error("pushed symbol age not zero");

endmodule

`default_nettype wire

[rtl/sgh_hist_mem.sv]
// sgh_hist_mem: histogram bin store with per-bin valid bits and write forwarding
// depends on sgh_pkg (t_hist_ctl)
`default_nettype none

module sgh_hist_mem #(
    parameter int MAX_GAP     = 128,
    parameter int COUNT_WIDTH = 32,
    localparam int DEPTH      = MAX_GAP + 1,
    localparam int ADDR_W     = $clog2(MAX_GAP + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire sgh_pkg::t_hist_ctl     i_ctl,
    input  wire logic [ADDR_W-1:0]      i_rd_addr,
    input  wire logic [ADDR_W-1:0]      i_wr_addr,
    input  wire logic [COUNT_WIDTH-1:0] i_wr_data,
    output logic      [COUNT_WIDTH-1:0] o_rd_data
);

    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]       r_valid;

    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_valid;
    logic                   r_fwd_hit;
    logic [COUNT_WIDTH-1:0] r_fwd_data;
    logic                   r_clr_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read side; a write or clear on the same edge is caught by the bypass flags
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
            r_fwd_hit  <= i_ctl.wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
            r_clr_hit  <= i_ctl.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            o_rd_data = r_fwd_data;
        end else if (r_clr_hit || !r_rd_valid) begin
            o_rd_data = '0;
        end else begin
            o_rd_data = r_rd_data;
        end
    end

    // a read issued together with a clear must come back empty
    a_clear_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.clr && i_ctl.rd_en) |=> (o_rd_data == '0))
        else $error("read after clear not zero");

endmodule

`default_nettype wire

[rtl/symbol_repeat_gap_histogram_top.sv]
// symbol_repeat_gap_histogram_top: repeat-gap histogram over a symbol stream
// depends on sgh_pkg, sgh_age_track, sgh_hist_mem
`default_nettype none

// Takes one request per cycle on a valid/ready channel while the output is not
// stalled and returns exactly one result per request. The result is registered
// and held on the output until it is taken. A push request looks up the saturating
// age of its symbol (the repeat gap), bumps the matching histogram bin if the gap
// is 0..MAX_GAP and restarts the symbol's age; a read request returns the count of
// one bin; a clear request empties ages and bins at once (per-bin valid bits, no
// sweep). The pipeline is input register -> age lookup and bin read -> bin
// increment and write -> output register. The bin store is one read and one write
// port; back-to-back pushes to the same bin are bypassed, so throughput stays at
// one request per cycle while the output is not stalled.

module symbol_repeat_gap_histogram_top #(
    parameter int SYMBOL_BITS = sgh_pkg::DEF_SYMBOL_BITS,
    parameter int MAX_GAP     = sgh_pkg::DEF_MAX_GAP,
    parameter int COUNT_WIDTH = sgh_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [sgh_pkg::OP_W-1:0]          i_operation,
    input  wire logic [sgh_pkg::SYMBOL_W-1:0]      i_symbol,
    input  wire logic [sgh_pkg::INDEX_W-1:0]       i_bin_index,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [sgh_pkg::GAP_OUT_W-1:0]     o_gap_seen,
    output logic                                   o_counted,
    output logic      [sgh_pkg::COUNT_OUT_W-1:0]   o_bin_count
);

    localparam int AGE_W  = $clog2(MAX_GAP + 2);
    localparam int ADDR_W = $clog2(MAX_GAP + 1);
    localparam logic [AGE_W-1:0] UNSEEN = AGE_W'(MAX_GAP + 1);

    // ---- stage 1: input register ----
    logic                       r_s1_vld;
    sgh_pkg::t_op               r_s1_op;
    logic [SYMBOL_BITS-1:0]     r_s1_sym;
    logic [sgh_pkg::INDEX_W-1:0] r_s1_idx;

    // ---- stage 2: bin read returned ----
    logic                       r_s2_vld;
    sgh_pkg::t_op               r_s2_op;
    logic [AGE_W-1:0]           r_s2_gap;
    logic                       r_s2_hit;
    logic                       r_s2_idx_ok;
    logic [ADDR_W-1:0]          r_s2_addr;

    // ---- output register ----
    logic                                 r_out_vld;
    logic [sgh_pkg::GAP_OUT_W-1:0]        r_out_gap;
    logic                                 r_out_counted;
    logic [sgh_pkg::COUNT_OUT_W-1:0]      r_out_count;

    logic                       w_s1_adv;
    logic                       w_s2_adv;
    logic [SYMBOL_BITS+sgh_pkg::SYMBOL_W-1:0] w_sym_ext;
    logic [ADDR_W+sgh_pkg::INDEX_W-1:0]       w_idx_ext;
    logic [AGE_W-1:0]           w_age;
    logic                       w_seen;
    logic                       w_s1_push;
    logic                       w_s1_idx_ok;
    logic [ADDR_W-1:0]          w_rd_addr;
    sgh_pkg::t_hist_ctl         w_ctl;
    logic [COUNT_WIDTH-1:0]     w_cur;
    logic                       w_sat;
    logic [COUNT_WIDTH-1:0]     w_inc;
    logic [COUNT_WIDTH+sgh_pkg::COUNT_OUT_W-1:0] w_cnt_ext;
    logic [AGE_W+sgh_pkg::GAP_OUT_W-1:0]         w_gap_ext;
    logic [sgh_pkg::GAP_OUT_W-1:0]        n_out_gap;
    logic                                 n_out_counted;
    logic [sgh_pkg::COUNT_OUT_W-1:0]      n_out_count;

    // handshake chain: each stage moves when the one after it frees up
    assign w_s2_adv   = r_s2_vld && (!r_out_vld || i_out_ready);
    assign w_s1_adv   = r_s1_vld && (!r_s2_vld || w_s2_adv);
    assign o_in_ready = !r_s1_vld || w_s1_adv;

    // only the low SYMBOL_BITS of the symbol select an age
    assign w_sym_ext = {{SYMBOL_BITS{1'b0}}, i_symbol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_op  <= sgh_pkg::t_op'(i_operation);
            r_s1_sym <= w_sym_ext[SYMBOL_BITS-1:0];
            r_s1_idx <= i_bin_index;
        end
    end

    // ages move forward as the request leaves stage 1, so the next one sees them
    sgh_age_track #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .MAX_GAP     (MAX_GAP)
    ) u_age (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (r_s1_sym),
        .i_upd   (w_s1_adv && (r_s1_op == sgh_pkg::OP_PUSH)),
        .i_clr   (w_s1_adv && (r_s1_op == sgh_pkg::OP_CLEAR)),
        .o_age   (w_age),
        .o_seen  (w_seen)
    );

    assign w_s1_push   = (r_s1_op == sgh_pkg::OP_PUSH) && w_seen;
    assign w_s1_idx_ok = (32'(r_s1_idx) <= 32'(MAX_GAP));
    assign w_idx_ext   = {{ADDR_W{1'b0}}, r_s1_idx};

    // bin address: the gap for a push of a seen symbol, the index for an in-range read, else bin zero
    always_comb begin
        if (w_s1_push) begin
            w_rd_addr = w_age[ADDR_W-1:0];
        end else if ((r_s1_op == sgh_pkg::OP_READ) && w_s1_idx_ok) begin
            w_rd_addr = w_idx_ext[ADDR_W-1:0];
        end else begin
            w_rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_vld <= 1'b1;
        end else if (w_s2_adv) begin
            r_s2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_op     <= r_s1_op;
            r_s2_gap    <= w_seen ? w_age : UNSEEN;
            r_s2_hit    <= w_s1_push;
            r_s2_idx_ok <= w_s1_idx_ok;
            r_s2_addr   <= w_rd_addr;
        end
    end

    // saturating increment of the fetched bin
    assign w_sat = &w_cur;
    assign w_inc = w_cur + 1'b1;

    always_comb begin
        w_ctl.rd_en = w_s1_adv;
        w_ctl.wr_en = w_s2_adv && (r_s2_op == sgh_pkg::OP_PUSH) && r_s2_hit && !w_sat;
        w_ctl.clr   = w_s2_adv && (r_s2_op == sgh_pkg::OP_CLEAR);
    end

    sgh_hist_mem #(
        .MAX_GAP     (MAX_GAP),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (r_s2_addr),
        .i_wr_data (w_inc),
        .o_rd_data (w_cur)
    );

    // result fields, truncated or zero-extended to the port widths
    assign w_cnt_ext = {{sgh_pkg::COUNT_OUT_W{1'b0}}, w_cur};
    assign w_gap_ext = {{sgh_pkg::GAP_OUT_W{1'b0}}, r_s2_gap};

    always_comb begin
        n_out_gap     = '0;
        n_out_counted = 1'b0;
        n_out_count   = '0;
        case (r_s2_op)
            sgh_pkg::OP_PUSH: begin
                n_out_gap     = w_gap_ext[sgh_pkg::GAP_OUT_W-1:0];
                n_out_counted = r_s2_hit;
            end
            sgh_pkg::OP_READ: begin
                if (r_s2_idx_ok) begin
                    n_out_count = w_cnt_ext[sgh_pkg::COUNT_OUT_W-1:0];
                end
            end
            default: begin
                n_out_gap = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s2_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_out_gap     <= n_out_gap;
            r_out_counted <= n_out_counted;
            r_out_count   <= n_out_count;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_gap_seen  = r_out_gap;
    assign o_counted   = r_out_counted;
    assign o_bin_count = r_out_count;

    // a stalled stage 2 request keeps its gap and its place
    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && !w_s2_adv) |=> (r_s2_vld && $stable(r_s2_gap) && $stable(r_s2_op)))
        else $error("stage 2 request lost while stalled");

    // a counted push never carries a bin count
    a_counted_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_counted) |-> (o_bin_count == '0))
        else $error("counted push with nonzero bin count");

endmodule

`default_nettype wire
